// ===== sv/sct_pkg.sv =====
// shared types and constants of the sip call state tracker
`default_nettype none
package sct_pkg;

	localparam logic [2:0] KIND_RESPONSE = 3'd0;
	localparam logic [2:0] KIND_INVITE   = 3'd1;
	localparam logic [2:0] KIND_ACK      = 3'd2;
	localparam logic [2:0] KIND_CANCEL   = 3'd3;
	localparam logic [2:0] KIND_BYE      = 3'd4;

	localparam logic [9:0] CODE_TEMP_UNAVAIL = 10'd480;
	localparam logic [9:0] CODE_BUSY_HERE    = 10'd486;
	localparam logic [9:0] CODE_BUSY_EVERY   = 10'd600;
	localparam logic [9:0] CODE_REJECT_MIN   = 10'd400;
	localparam logic [9:0] CODE_DIVERT_MIN   = 10'd300;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_SETUP     = 3'd1,
		ST_INCALL    = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_REJECTED  = 3'd4,
		ST_BUSY      = 3'd5,
		ST_DIVERTED  = 3'd6,
		ST_COMPLETED = 3'd7
	} call_state_t;

	typedef struct packed {
		logic        first_of_call;
		logic [2:0]  method_kind;
		logic [9:0]  status_code;
		logic [31:0] cseq_number;
	} msg_word_t;

	typedef struct packed {
		call_state_t call_state_out;
		logic        talk_started;
		logic        talk_ended;
		logic        is_invite_dialog;
	} res_word_t;

	// classified message as it travels from front to back
	typedef struct packed {
		logic        first;
		logic        is_invite;
		logic        is_ack;
		logic        is_cancel;
		logic        is_bye;
		logic        busy_code;
		logic        reject_code;
		logic        divert_code;
		logic [31:0] cseq;
	} cls_word_t;

endpackage
`default_nettype wire

// ===== sv/sct_front.sv =====
// front part: decodes method and response code of an incoming word
`default_nettype none
module sct_front (
	input  sct_pkg::msg_word_t msg,
	output sct_pkg::cls_word_t cls
);
	import sct_pkg::*;

	logic is_resp;

	always_comb begin
		is_resp         = (msg.method_kind == KIND_RESPONSE);
		cls.first       = msg.first_of_call;
		cls.is_invite   = (msg.method_kind == KIND_INVITE);
		cls.is_ack      = (msg.method_kind == KIND_ACK);
		cls.is_cancel   = (msg.method_kind == KIND_CANCEL);
		cls.is_bye      = (msg.method_kind == KIND_BYE);
		cls.busy_code   = is_resp && (msg.status_code == CODE_TEMP_UNAVAIL
			|| msg.status_code == CODE_BUSY_HERE || msg.status_code == CODE_BUSY_EVERY);
		cls.reject_code = is_resp && (msg.status_code > CODE_REJECT_MIN);
		cls.divert_code = is_resp && (msg.status_code > CODE_DIVERT_MIN);
		cls.cseq        = msg.cseq_number;
	end

endmodule
`default_nettype wire

// ===== sv/sct_queue.sv =====
// short queue of classified words between front and back
`default_nettype none
module sct_queue #(
	parameter int DEPTH = 2
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  sct_pkg::cls_word_t push_word,
	output logic               full,
	input  wire                pop,
	output sct_pkg::cls_word_t pop_word,
	output logic               empty
);
	import sct_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_word_t         slot_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_word = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/sct_back.sv =====
// back part: call state machine and result register
`default_nettype none
module sct_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cls_valid,
	input  sct_pkg::cls_word_t cls,
	output logic               cls_pop,
	output logic               res_valid,
	input  wire                res_ready,
	output sct_pkg::res_word_t res
);
	import sct_pkg::*;

	call_state_t state_q;
	logic [31:0] invite_seq_q;
	logic        began_invite_q;
	logic        res_valid_q;
	res_word_t   res_q;

	call_state_t cur_state;
	call_state_t next_state;
	logic [31:0] cur_seq;
	logic [31:0] next_seq;
	logic        cur_began;
	logic        seq_match;
	logic        started;
	logic        ended;

	assign cls_pop   = cls_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a first word of a call clears the state before it is applied
	always_comb begin
		cur_state = cls.first ? ST_NONE : state_q;
		cur_seq   = cls.first ? '0 : invite_seq_q;
		cur_began = cls.first ? cls.is_invite : began_invite_q;
		seq_match = (cls.cseq == cur_seq);
	end

	always_comb begin
		next_state = cur_state;
		next_seq   = cur_seq;
		if (cur_began) begin
			unique case (cur_state)
				ST_SETUP: begin
					if (cls.is_ack && seq_match) begin
						next_state = ST_INCALL;
					end else if (cls.is_cancel) begin
						next_state = ST_CANCELLED;
					end else if (cls.busy_code) begin
						next_state = ST_BUSY;
					end else if (cls.reject_code && seq_match) begin
						next_state = ST_REJECTED;
					end else if (cls.divert_code) begin
						next_state = ST_DIVERTED;
					end
				end
				ST_INCALL: begin
					if (cls.is_bye) begin
						next_state = ST_COMPLETED;
					end
				end
				default: begin
					if (cls.is_invite) begin
						next_state = ST_SETUP;
						next_seq   = cls.cseq;
					end
				end
			endcase
		end
	end

	always_comb begin
		started = cur_began && (cur_state == ST_SETUP) && cls.is_ack && seq_match;
		ended   = cur_began && (cur_state == ST_INCALL) && cls.is_bye;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_NONE;
			invite_seq_q   <= '0;
			began_invite_q <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cls_pop) begin
				state_q        <= next_state;
				invite_seq_q   <= next_seq;
				began_invite_q <= cur_began;
				res_valid_q    <= 1'b1;
			end else if (res_ready) begin
				res_valid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop) begin
			res_q.call_state_out   <= next_state;
			res_q.talk_started     <= started;
			res_q.talk_ended       <= ended;
			res_q.is_invite_dialog <= cur_began;
		end
	end

endmodule
`default_nettype wire

// ===== sv/sip_call_state_tracker_top.sv =====
// sip call state tracker: one sip message word in, one call state word out
//
// msg channel (msg_valid/msg_ready/msg) takes one message word per cycle
// when msg_ready is high: first-of-call, method kind, response code, cseq.
// res channel (res_valid/res_ready/res) gives one word per message: the
// call state after the message, talk start and talk end markers and the
// invite dialog flag, in message order.
// a word is decoded as it is accepted and lands in the queue; the back part
// takes it from the queue into the result register once that register is
// free or res_ready takes its word, and res_valid then rises.
// throughput: one word per cycle while res_ready is high.
// the queue of QUEUE_DEPTH words lets msg keep flowing while res stalls;
// msg_ready drops only when the queue is full, and the result register
// holds its word until res_ready takes it.
// reset clears the call state to none, the stored cseq and the invite
// flag, and empties the queue and the result register.
`default_nettype none
module sip_call_state_tracker_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                msg_valid,
	output logic               msg_ready,
	input  sct_pkg::msg_word_t msg,
	output logic               res_valid,
	input  wire                res_ready,
	output sct_pkg::res_word_t res
);
	import sct_pkg::*;

	cls_word_t front_cls;
	cls_word_t queue_cls;
	logic      queue_full;
	logic      queue_empty;
	logic      queue_pop;
	logic      msg_take;

	assign msg_ready = !queue_full;
	assign msg_take  = msg_valid && msg_ready;

	sct_front u_front (
		.msg (msg),
		.cls (front_cls)
	);

	sct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (msg_take),
		.push_word (front_cls),
		.full      (queue_full),
		.pop       (queue_pop),
		.pop_word  (queue_cls),
		.empty     (queue_empty)
	);

	sct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (!queue_empty),
		.cls       (queue_cls),
		.cls_pop   (queue_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.talk_started |-> res.call_state_out == ST_INCALL)
		else $error("talk start without in call state");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.talk_ended |-> res.call_state_out == ST_COMPLETED)
		else $error("talk end without completed state");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.call_state_out != ST_NONE |-> res.is_invite_dialog)
		else $error("state moved in a call that did not begin with invite");

	assert property (@(posedge clk) disable iff (!arst_n)
		queue_full |-> !queue_empty && res_valid)
		else $error("queue filled while result register was free");
`endif

endmodule
`default_nettype wire
